### rtl/heading_limited_grid_router_unit_defines.svh
// ------------------------------------------------------------------------
// heading limited grid router assertion macros
// shared property wrappers, clocked on clk with synchronous reset rst_n
// ------------------------------------------------------------------------
`ifndef HEADING_LIMITED_GRID_ROUTER_UNIT_DEFINES_SVH
`define HEADING_LIMITED_GRID_ROUTER_UNIT_DEFINES_SVH

// same-cycle implication
`define HLGR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HLGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/hlgr_pkg.sv
// ------------------------------------------------------------------------
// hlgr_pkg
// types, constants and heading helpers for the heading limited grid router
// ------------------------------------------------------------------------
`default_nettype none

package hlgr_pkg;

  localparam int HLGR_GRID_SIZE   = 64;
  localparam int HLGR_MAX_CORNERS = 64;

  // result status codes
  localparam logic [1:0] STATUS_FOUND    = 2'd0;
  localparam logic [1:0] STATUS_NO_ROUTE = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // parent mark of states queued by the start cell
  localparam logic [3:0] MARK_START = 4'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEED,
    ST_TRY_SEL,
    ST_TRY_CHK,
    ST_POP_RD,
    ST_POP_CHK,
    ST_BT_RD,
    ST_BT_CHK,
    ST_BT_START,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } hlgr_state_t;

  // column step of a heading
  function automatic logic signed [1:0] step_dx(input logic [2:0] h);
    logic signed [1:0] d;
    case (h)
      3'd1, 3'd2, 3'd3: d = 2'sb01;
      3'd5, 3'd6, 3'd7: d = 2'sb11;
      default:          d = 2'sb00;
    endcase
    return d;
  endfunction

  // row step of a heading
  function automatic logic signed [1:0] step_dy(input logic [2:0] h);
    logic signed [1:0] d;
    case (h)
      3'd0, 3'd1, 3'd7: d = 2'sb11;
      3'd3, 3'd4, 3'd5: d = 2'sb01;
      default:          d = 2'sb00;
    endcase
    return d;
  endfunction

  // heading from delta signs, msb is valid (clear when both deltas are zero)
  function automatic logic [3:0] aim(input logic gx, input logic lx,
                                     input logic gy, input logic ly);
    logic [3:0] r;
    if (ly) begin
      r = gx ? 4'b1001 : (lx ? 4'b1111 : 4'b1000);
    end else if (gy) begin
      r = gx ? 4'b1011 : (lx ? 4'b1101 : 4'b1100);
    end else begin
      r = gx ? 4'b1010 : (lx ? 4'b1110 : 4'b0000);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/heading_limited_grid_router_unit.sv
// ------------------------------------------------------------------------
// heading_limited_grid_router_unit
// breadth-first maze router over (cell, heading) states with 45 degree turns
// ------------------------------------------------------------------------
// A request is taken when start is high and busy is low. busy falls in the
// cycle that shows the last result, so the next request can be taken there.
// Results appear one per strobe on out_valid and cannot be held off, so the
// receiver must take every one. A request whose start equals its target
// answers in the cycle after the transfer and busy does not rise. Every other
// request first sweeps the state memory clear, one entry a cycle, then seeds
// the start state. Each queue pop reads the queue memory and then checks the
// popped state; each candidate heading that is allowed and on the grid reads
// the state memory and then is checked, skipped candidates are stepped past,
// and the expansion closes when all are tried. An empty queue ends the
// search. The backtrace reads and checks the state memory for each route
// step, and the output reads the corner buffer and then shows each corner.
`default_nettype none

`include "heading_limited_grid_router_unit_defines.svh"

module heading_limited_grid_router_unit #(
  parameter int GRID_SIZE   = hlgr_pkg::HLGR_GRID_SIZE,
  parameter int MAX_CORNERS = hlgr_pkg::HLGR_MAX_CORNERS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [5:0] in_start_x,
  input  logic [5:0] in_start_y,
  input  logic       in_has_previous,
  input  logic [5:0] in_previous_x,
  input  logic [5:0] in_previous_y,
  input  logic [5:0] in_target_x,
  input  logic [5:0] in_target_y,
  output logic       out_valid,
  output logic [1:0] out_route_status,
  output logic [5:0] out_corner_x,
  output logic [5:0] out_corner_y,
  output logic       out_last
);

  import hlgr_pkg::*;

  localparam int NUM_STATES = GRID_SIZE * GRID_SIZE * 8;
  localparam int SW  = $clog2(NUM_STATES);
  localparam int CW  = $clog2(GRID_SIZE);
  localparam int XW  = ((CW > 6) ? CW : 6) + 2;
  localparam int QW  = 2 * CW + 3;
  localparam int CNW = $clog2(MAX_CORNERS + 1);
  localparam int CBW = $clog2(MAX_CORNERS);
  localparam logic [SW-1:0] CLR_LAST = SW'(NUM_STATES - 1);
  localparam logic signed [XW-1:0] GRID_LIM = XW'(GRID_SIZE);

  // state index of a cell and heading
  function automatic logic [SW-1:0] state_idx(input logic signed [XW-1:0] x,
                                               input logic signed [XW-1:0] y,
                                               input logic [2:0] h);
    logic [SW-1:0] c;
    c = SW'(unsigned'(y)) * SW'(GRID_SIZE) + SW'(unsigned'(x));
    return {c[SW-4:0], h};
  endfunction

  // control and request registers
  hlgr_state_t state_r, state_nxt;
  logic [SW-1:0]          clr_r, clr_nxt;
  logic [SW:0]            q_head_r, q_head_nxt, q_tail_r, q_tail_nxt;
  logic [CNW-1:0]         count_r, count_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [5:0]             sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [XW-1:0]   tx_r, tx_nxt, ty_r, ty_nxt;
  logic                   sh_v_r, sh_v_nxt;
  logic [2:0]             sh_r, sh_nxt;
  logic signed [XW-1:0]   cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [2:0]             cur_h_r, cur_h_nxt;
  logic                   cur_hl_r, cur_hl_nxt;
  logic [3:0]             mark_r, mark_nxt;
  logic [3:0]             try_r, try_nxt;
  logic signed [XW-1:0]   nb_x_r, nb_x_nxt, nb_y_r, nb_y_nxt;
  logic [2:0]             nb_h_r, nb_h_nxt;
  logic                   le_v_r, le_v_nxt;
  logic [2:0]             le_r, le_nxt;
  logic [CBW-1:0]         ptr_r, ptr_nxt;
  logic [1:0]             o_status_r, o_status_nxt;
  logic [5:0]             o_x_r, o_x_nxt, o_y_r, o_y_nxt;
  logic                   o_last_r, o_last_nxt;

  // memories and their ports
  logic [4:0]    vmem [NUM_STATES];
  logic [QW-1:0] qmem [NUM_STATES];
  logic [11:0]   cmem [MAX_CORNERS];
  logic [4:0]    vm_q_r;
  logic [QW-1:0] qm_q_r;
  logic [11:0]   cm_q_r;
  logic          vm_we, vm_re, qm_we, qm_re, cm_we, cm_re;
  logic [SW-1:0] vm_waddr, vm_raddr;
  logic [4:0]    vm_wdata;
  logic [11:0]   cm_wdata;

  // request decode
  logic acc, same;
  logic [3:0] st_aim;
  assign acc    = start && !busy;
  assign same   = (in_start_x == in_target_x) && (in_start_y == in_target_y);
  assign st_aim = aim(in_start_x > in_previous_x, in_start_x < in_previous_x,
                      in_start_y > in_previous_y, in_start_y < in_previous_y);

  // neighbor selection for the current expansion
  logic [3:0] opt;
  logic [2:0] n1, n2, slot_hd;
  logic slot_en, try_done, nb_in;
  logic signed [XW-1:0] nx, ny;
  assign opt = aim(tx_r > cur_x_r, tx_r < cur_x_r, ty_r > cur_y_r, ty_r < cur_y_r);
  assign n1  = cur_h_r - 3'd1;
  assign n2  = cur_h_r + 3'd1;
  always_comb begin
    slot_hd = cur_h_r;
    slot_en = 1'b1;
    if (try_r == 4'd0) begin
      slot_hd = opt[2:0];
      slot_en = opt[3] && (cur_hl_r || opt[2:0] == cur_h_r || opt[2:0] == n1 ||
                           opt[2:0] == n2);
    end else if (cur_hl_r) begin
      slot_hd = 3'(try_r - 4'd1);
    end else begin
      case (try_r)
        4'd1:    slot_hd = cur_h_r;
        4'd2:    slot_hd = n1;
        default: slot_hd = n2;
      endcase
    end
  end
  assign try_done = cur_hl_r ? (try_r > 4'd8) : (try_r > 4'd3);
  assign nx    = cur_x_r + XW'(step_dx(slot_hd));
  assign ny    = cur_y_r + XW'(step_dy(slot_hd));
  assign nb_in = !nx[XW-1] && !ny[XW-1] && (nx < GRID_LIM) && (ny < GRID_LIM);

  // queue pop decode
  logic q_empty, p_hit;
  logic signed [XW-1:0] p_x, p_y;
  logic [2:0] p_h;
  assign q_empty = (q_head_r == q_tail_r);
  assign p_x   = XW'(qm_q_r[CW-1:0]);
  assign p_y   = XW'(qm_q_r[2*CW-1:CW]);
  assign p_h   = qm_q_r[QW-1:2*CW];
  assign p_hit = (p_x == tx_r) && (p_y == ty_r);

  // backtrace corner recording
  logic rec_en, seed_en;
  logic [5:0] rec_x, rec_y;
  logic [CNW-1:0] count_inc;
  always_comb begin
    rec_en = 1'b0;
    rec_x  = cur_x_r[5:0];
    rec_y  = cur_y_r[5:0];
    if (state_r == ST_BT_CHK) begin
      rec_en = !le_v_r || (cur_h_r != le_r);
    end else if (state_r == ST_BT_START) begin
      rec_en = !sh_v_r || (sh_r != le_r);
      rec_x  = sx_r;
      rec_y  = sy_r;
    end
  end
  assign count_inc = count_r + CNW'(1);
  assign seed_en   = sh_v_r && (sx_r < GRID_LIM[5:0] || GRID_SIZE >= 64) &&
                     (sy_r < GRID_LIM[5:0] || GRID_SIZE >= 64);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (acc && !same) state_nxt = ST_CLEAR;
      ST_CLEAR:    if (clr_r == CLR_LAST) state_nxt = ST_SEED;
      ST_SEED:     state_nxt = ST_TRY_SEL;
      ST_TRY_SEL: begin
        if (try_done) state_nxt = ST_POP_RD;
        else if (slot_en && nb_in) state_nxt = ST_TRY_CHK;
      end
      ST_TRY_CHK:  state_nxt = ST_TRY_SEL;
      ST_POP_RD:   state_nxt = q_empty ? ST_IDLE : ST_POP_CHK;
      ST_POP_CHK:  state_nxt = p_hit ? ST_BT_RD : ST_TRY_SEL;
      ST_BT_RD:    state_nxt = ST_BT_CHK;
      ST_BT_CHK:   state_nxt = vm_q_r[3] ? ST_BT_START : ST_BT_RD;
      ST_BT_START: state_nxt = ST_EMIT_RD;
      ST_EMIT_RD:  state_nxt = ovf_r ? ST_IDLE : ST_EMIT_OUT;
      ST_EMIT_OUT: state_nxt = (ptr_r == '0) ? ST_IDLE : ST_EMIT_RD;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath, memory ports and outputs
  always_comb begin
    clr_nxt = clr_r;  q_head_nxt = q_head_r;  q_tail_nxt = q_tail_r;
    count_nxt = count_r;  ovf_nxt = ovf_r;  out_valid_nxt = 1'b0;
    sx_nxt = sx_r;  sy_nxt = sy_r;  tx_nxt = tx_r;  ty_nxt = ty_r;
    sh_v_nxt = sh_v_r;  sh_nxt = sh_r;
    cur_x_nxt = cur_x_r;  cur_y_nxt = cur_y_r;  cur_h_nxt = cur_h_r;
    cur_hl_nxt = cur_hl_r;  mark_nxt = mark_r;  try_nxt = try_r;
    nb_x_nxt = nb_x_r;  nb_y_nxt = nb_y_r;  nb_h_nxt = nb_h_r;
    le_v_nxt = le_v_r;  le_nxt = le_r;  ptr_nxt = ptr_r;
    o_status_nxt = o_status_r;  o_x_nxt = o_x_r;  o_y_nxt = o_y_r;
    o_last_nxt = o_last_r;
    vm_we = 1'b0;  vm_re = 1'b0;  vm_waddr = clr_r;  vm_raddr = '0;
    vm_wdata = 5'b0;
    qm_we = 1'b0;  qm_re = 1'b0;
    cm_we = 1'b0;  cm_re = 1'b0;  cm_wdata = {rec_y, rec_x};

    // corner record into the buffer, overflow beyond its depth
    if (rec_en) begin
      if (count_r < CNW'(MAX_CORNERS)) begin
        cm_we = 1'b1;
        count_nxt = count_inc;
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          sx_nxt = in_start_x;  sy_nxt = in_start_y;
          tx_nxt = XW'(in_target_x);  ty_nxt = XW'(in_target_y);
          sh_v_nxt = in_has_previous && st_aim[3];
          sh_nxt = st_aim[2:0];
          cur_x_nxt = XW'(in_start_x);  cur_y_nxt = XW'(in_start_y);
          cur_h_nxt = st_aim[2:0];
          cur_hl_nxt = !(in_has_previous && st_aim[3]);
          mark_nxt = MARK_START;  try_nxt = 4'd0;
          clr_nxt = '0;  q_head_nxt = '0;  q_tail_nxt = '0;
          if (same) begin
            out_valid_nxt = 1'b1;
            o_status_nxt = STATUS_FOUND;
            o_x_nxt = in_start_x;  o_y_nxt = in_start_y;  o_last_nxt = 1'b1;
          end
        end
      end
      ST_CLEAR: begin
        vm_we = 1'b1;
        clr_nxt = clr_r + SW'(1);
      end
      ST_SEED: begin
        vm_we = seed_en;
        vm_waddr = state_idx(XW'(sx_r), XW'(sy_r), sh_r);
        vm_wdata = {1'b1, MARK_START};
      end
      ST_TRY_SEL: begin
        if (!try_done) begin
          if (slot_en && nb_in) begin
            vm_re = 1'b1;
            vm_raddr = state_idx(nx, ny, slot_hd);
            nb_x_nxt = nx;  nb_y_nxt = ny;  nb_h_nxt = slot_hd;
          end else begin
            try_nxt = try_r + 4'd1;
          end
        end
      end
      ST_TRY_CHK: begin
        if (!vm_q_r[4]) begin
          vm_we = 1'b1;
          vm_waddr = state_idx(nb_x_r, nb_y_r, nb_h_r);
          vm_wdata = {1'b1, mark_r};
          qm_we = 1'b1;
          q_tail_nxt = q_tail_r + (SW+1)'(1);
        end
        try_nxt = try_r + 4'd1;
      end
      ST_POP_RD: begin
        if (q_empty) begin
          out_valid_nxt = 1'b1;
          o_status_nxt = STATUS_NO_ROUTE;
          o_x_nxt = 6'd0;  o_y_nxt = 6'd0;  o_last_nxt = 1'b1;
        end else begin
          qm_re = 1'b1;
          q_head_nxt = q_head_r + (SW+1)'(1);
        end
      end
      ST_POP_CHK: begin
        cur_x_nxt = p_x;  cur_y_nxt = p_y;  cur_h_nxt = p_h;
        cur_hl_nxt = 1'b0;  mark_nxt = {1'b0, p_h};  try_nxt = 4'd0;
        le_v_nxt = 1'b0;  count_nxt = '0;  ovf_nxt = 1'b0;
      end
      ST_BT_RD: begin
        vm_re = 1'b1;
        vm_raddr = state_idx(cur_x_r, cur_y_r, cur_h_r);
      end
      ST_BT_CHK: begin
        le_v_nxt = 1'b1;
        le_nxt = cur_h_r;
        cur_x_nxt = cur_x_r - XW'(step_dx(cur_h_r));
        cur_y_nxt = cur_y_r - XW'(step_dy(cur_h_r));
        cur_h_nxt = vm_q_r[2:0];
      end
      ST_BT_START: begin
        ptr_nxt = CBW'(count_nxt - CNW'(1));
      end
      ST_EMIT_RD: begin
        if (ovf_r) begin
          out_valid_nxt = 1'b1;
          o_status_nxt = STATUS_OVERFLOW;
          o_x_nxt = 6'd0;  o_y_nxt = 6'd0;  o_last_nxt = 1'b1;
        end else begin
          cm_re = 1'b1;
        end
      end
      ST_EMIT_OUT: begin
        out_valid_nxt = 1'b1;
        o_status_nxt = STATUS_FOUND;
        o_x_nxt = cm_q_r[5:0];  o_y_nxt = cm_q_r[11:6];
        o_last_nxt = (ptr_r == '0);
        ptr_nxt = ptr_r - CBW'(1);
      end
      default: begin
      end
    endcase
  end

  // state memory: visited bit and parent mark
  always_ff @(posedge clk) begin
    if (vm_we) vmem[vm_waddr] <= vm_wdata;
    if (vm_re) vm_q_r <= vmem[vm_raddr];
  end

  // search queue memory
  always_ff @(posedge clk) begin
    if (qm_we) qmem[q_tail_r[SW-1:0]] <= {nb_h_r, nb_y_r[CW-1:0], nb_x_r[CW-1:0]};
    if (qm_re) qm_q_r <= qmem[q_head_r[SW-1:0]];
  end

  // corner buffer memory
  always_ff @(posedge clk) begin
    if (cm_we) cmem[count_r[CBW-1:0]] <= cm_wdata;
    if (cm_re) cm_q_r <= cmem[ptr_r];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      q_head_r <= '0;
      q_tail_r <= '0;
      count_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      q_head_r <= q_head_nxt;
      q_tail_r <= q_tail_nxt;
      count_r <= count_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    clr_r <= clr_nxt;  sx_r <= sx_nxt;  sy_r <= sy_nxt;
    tx_r <= tx_nxt;  ty_r <= ty_nxt;  sh_v_r <= sh_v_nxt;  sh_r <= sh_nxt;
    cur_x_r <= cur_x_nxt;  cur_y_r <= cur_y_nxt;  cur_h_r <= cur_h_nxt;
    cur_hl_r <= cur_hl_nxt;  mark_r <= mark_nxt;  try_r <= try_nxt;
    nb_x_r <= nb_x_nxt;  nb_y_r <= nb_y_nxt;  nb_h_r <= nb_h_nxt;
    le_v_r <= le_v_nxt;  le_r <= le_nxt;  ptr_r <= ptr_nxt;
    o_status_r <= o_status_nxt;  o_x_r <= o_x_nxt;  o_y_r <= o_y_nxt;
    o_last_r <= o_last_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_route_status = o_status_r;
  assign out_corner_x     = o_x_r;
  assign out_corner_y     = o_y_r;
  assign out_last         = o_last_r;

  // checks
  `HLGR_ASSERT_NOW(a_queue_order, 1'b1, q_head_r <= q_tail_r, "queue head passed tail")
  `HLGR_ASSERT_NOW(a_count_range, 1'b1, count_r <= CNW'(MAX_CORNERS), "corner count overrun")
  `HLGR_ASSERT_NEXT(a_bt_read, state_r == ST_BT_RD, state_r == ST_BT_CHK, "backtrace lost read")
  `HLGR_ASSERT_NEXT(a_more_results, out_valid && !out_last, busy, "idle before last result")

endmodule

`default_nettype wire

### test/tb_heading_limited_grid_router_unit.sv
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// tb_heading_limited_grid_router_unit
// self-checking bench: route requests are driven through the start/busy
// handshake, a scoreboard runs its own heading-limited breadth-first search
// per accepted request and compares every strobed corner in order
// ------------------------------------------------------------------------
`default_nettype none

module tb_heading_limited_grid_router_unit;
  import hlgr_pkg::*;

  localparam int GRID       = HLGR_GRID_SIZE;
  localparam int CORNER_CAP = HLGR_MAX_CORNERS;
  localparam int NUM_STATES = GRID * GRID * 8;
  localparam int STALL_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 40;

  // expected corner of one route
  typedef struct packed {
    logic [1:0] status;
    logic [5:0] x;
    logic [5:0] y;
    logic       last;
  } corner_t;

  class route_scoreboard;
    corner_t       corner_q[$];
    int            errors;
    bit            visited[NUM_STATES];
    logic [3:0]    parent[NUM_STATES];
    int unsigned   fifo[NUM_STATES];
    int unsigned   head;
    int unsigned   tail;
    int            dx[8] = '{0, 1, 1, 1, 0, -1, -1, -1};
    int            dy[8] = '{-1, -1, 0, 1, 1, 1, 0, -1};

    function new();
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // heading from a toward b, -1 when equal
    function int aim_from(int ax, int ay, int bx, int by);
      int sx;
      int sy;
      sx = (bx > ax) ? 1 : ((bx < ax) ? -1 : 0);
      sy = (by > ay) ? 1 : ((by < ay) ? -1 : 0);
      for (int i = 0; i < 8; i++) begin
        if (dx[i] == sx && dy[i] == sy) return i;
      end
      return -1;
    endfunction

    function int unsigned cell_state(int x, int y, int h);
      return (y * GRID + x) * 8 + h;
    endfunction

    function void try_add(int x, int y, int h, logic [3:0] mark);
      int unsigned idx;
      if (x < 0 || y < 0 || x >= GRID || y >= GRID) return;
      idx = cell_state(x, y, h);
      if (visited[idx]) return;
      visited[idx] = 1'b1;
      parent[idx] = mark;
      if (tail < NUM_STATES) begin
        fifo[tail] = idx;
        tail++;
      end
    endfunction

    // target heading first when allowed, then straight, left, right, or all eight when headless
    function void expand(int x, int y, int h, logic [3:0] mark, int tx, int ty);
      int opt;
      int n1;
      int n2;
      opt = aim_from(x, y, tx, ty);
      if (h < 0) begin
        if (opt >= 0) try_add(x + dx[opt], y + dy[opt], opt, mark);
        for (int i = 0; i < 8; i++) try_add(x + dx[i], y + dy[i], i, mark);
      end else begin
        n1 = (h + 7) & 7;
        n2 = (h + 1) & 7;
        if (opt >= 0 && (opt == h || opt == n1 || opt == n2))
          try_add(x + dx[opt], y + dy[opt], opt, mark);
        try_add(x + dx[h], y + dy[h], h, mark);
        try_add(x + dx[n1], y + dy[n1], n1, mark);
        try_add(x + dx[n2], y + dy[n2], n2, mark);
      end
    endfunction

    // search one accepted request and queue its corners
    function void note_request(int sx, int sy, bit hp, int px, int py, int tx, int ty);
      int start_h;
      int unsigned idx;
      int h;
      int x;
      int y;
      int le;
      logic [3:0] p;
      corner_t c;
      int cx[$];
      int cy[$];
      start_h = hp ? aim_from(px, py, sx, sy) : -1;
      if (sx == tx && sy == ty) begin
        c = '{STATUS_FOUND, sx[5:0], sy[5:0], 1'b1};
        corner_q = {corner_q, c};
        return;
      end
      visited = '{default: 1'b0};
      head = 0;
      tail = 0;
      if (start_h >= 0) visited[cell_state(sx, sy, start_h)] = 1'b1;
      expand(sx, sy, start_h, MARK_START, tx, ty);
      while (head < tail) begin
        idx = fifo[head];
        head++;
        h = idx & 7;
        x = (idx >> 3) % GRID;
        y = (idx >> 3) / GRID;
        if (x == tx && y == ty) begin
          // walk parents back, noting the end of each straight run
          le = -1;
          forever begin
            p = parent[idx];
            if (h != le) begin
              cx = {cx, x};
              cy = {cy, y};
              le = h;
            end
            x -= dx[h];
            y -= dy[h];
            if (p >= MARK_START) begin
              if (start_h != le) begin
                cx = {cx, sx};
                cy = {cy, sy};
              end
              break;
            end
            h = p;
            idx = cell_state(x, y, h);
          end
          if (cx.size() > CORNER_CAP) begin
            c = '{STATUS_OVERFLOW, 6'd0, 6'd0, 1'b1};
            corner_q = {corner_q, c};
            return;
          end
          for (int k = cx.size() - 1; k >= 0; k--) begin
            c.status = STATUS_FOUND;
            c.x = cx[k][5:0];
            c.y = cy[k][5:0];
            c.last = (k == 0);
            corner_q = {corner_q, c};
          end
          return;
        end
        expand(x, y, h, h[3:0], tx, ty);
      end
      c = '{STATUS_NO_ROUTE, 6'd0, 6'd0, 1'b1};
      corner_q = {corner_q, c};
    endfunction

    task check_result(logic [1:0] status, logic [5:0] x, logic [5:0] y, logic last);
      corner_t e;
      if (corner_q.size() == 0) begin
        report($sformatf("unexpected result status=%0d (%0d,%0d) last=%0b",
                         status, x, y, last));
        return;
      end
      e = corner_q.pop_front();
      if (status !== e.status)
        report($sformatf("status %0d, expected %0d", status, e.status));
      if (x !== e.x) report($sformatf("corner_x %0d, expected %0d", x, e.x));
      if (y !== e.y) report($sformatf("corner_y %0d, expected %0d", y, e.y));
      if (last !== e.last) report($sformatf("last %0b, expected %0b", last, e.last));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [5:0] in_start_x;
  logic [5:0] in_start_y;
  logic       in_has_previous;
  logic [5:0] in_previous_x;
  logic [5:0] in_previous_y;
  logic [5:0] in_target_x;
  logic [5:0] in_target_y;
  logic       out_valid;
  logic [1:0] out_route_status;
  logic [5:0] out_corner_x;
  logic [5:0] out_corner_y;
  logic       out_last;

  route_scoreboard sb;
  int              stall_count;
  bit              allow_idle;

  heading_limited_grid_router_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_has_previous (in_has_previous),
    .in_previous_x   (in_previous_x),
    .in_previous_y   (in_previous_y),
    .in_target_x     (in_target_x),
    .in_target_y     (in_target_y),
    .out_valid       (out_valid),
    .out_route_status(out_route_status),
    .out_corner_x    (out_corner_x),
    .out_corner_y    (out_corner_y),
    .out_last        (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result sampling and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_result(out_route_status, out_corner_x, out_corner_y, out_last);
      if (out_valid || (start && !busy)) begin
        stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  // one request transfer, with an optional idle burst ahead of it
  task send_request(int sx, int sy, bit hp, int px, int py, int tx, int ty);
    int gap;
    if (allow_idle && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start           = 1'b1;
    in_start_x      = sx[5:0];
    in_start_y      = sy[5:0];
    in_has_previous = hp;
    in_previous_x   = px[5:0];
    in_previous_y   = py[5:0];
    in_target_x     = tx[5:0];
    in_target_y     = ty[5:0];
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_request(sx, sy, hp, px, py, tx, ty);
  endtask

  function int clip(int v);
    return (v < 0) ? 0 : ((v > 63) ? 63 : v);
  endfunction

  // random request, mostly short routes to keep search time down
  task send_random(bit structured);
    int sx;
    int sy;
    int tx;
    int ty;
    int sel;
    sx = $urandom_range(0, 63);
    sy = $urandom_range(0, 63);
    sel = $urandom_range(0, 99);
    if (!structured || sel < 3) begin
      tx = $urandom_range(0, 63);
      ty = $urandom_range(0, 63);
    end else if (sel < 15) begin
      tx = sx;
      ty = sy;
    end else begin
      tx = clip(sx + $urandom_range(0, 10) - 5);
      ty = clip(sy + $urandom_range(0, 10) - 5);
    end
    if (sel < 25)
      send_request(sx, sy, $urandom_range(0, 1), sx, sy, tx, ty);
    else if (sel < 75)
      send_request(sx, sy, 1'b1, clip(sx + $urandom_range(0, 2) - 1),
                   clip(sy + $urandom_range(0, 2) - 1), tx, ty);
    else
      send_request(sx, sy, $urandom_range(0, 1), $urandom_range(0, 63),
                   $urandom_range(0, 63), tx, ty);
  endtask

  // stimulus
  initial begin
    sb              = new();
    stall_count     = 0;
    allow_idle      = 1'b1;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_start_x      = '0;
    in_start_y      = '0;
    in_has_previous = 1'b0;
    in_previous_x   = '0;
    in_previous_y   = '0;
    in_target_x     = '0;
    in_target_y     = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // start on the target, at both grid extremes
    send_request(0, 0, 1'b0, 0, 0, 0, 0);
    send_request(63, 63, 1'b1, 63, 62, 63, 63);
    // headless starts: no previous cell, previous equal to start
    send_request(10, 10, 1'b0, 0, 0, 13, 12);
    send_request(20, 20, 1'b1, 20, 20, 18, 24);
    // every first heading, each with a nearby target
    send_request(30, 30, 1'b1, 30, 31, 33, 28);
    send_request(30, 30, 1'b1, 29, 31, 27, 27);
    send_request(30, 30, 1'b1, 29, 30, 30, 34);
    send_request(30, 30, 1'b1, 29, 29, 26, 31);
    send_request(30, 30, 1'b1, 30, 29, 34, 30);
    send_request(30, 30, 1'b1, 31, 29, 33, 33);
    send_request(30, 30, 1'b1, 31, 30, 32, 30);
    send_request(30, 30, 1'b1, 31, 31, 28, 33);
    // heading pointing away from the target forces a turn-around
    send_request(5, 5, 1'b1, 4, 5, 2, 5);
    // grid edges and corners with the heading against the wall
    send_request(0, 0, 1'b1, 1, 1, 2, 0);
    send_request(63, 0, 1'b1, 62, 0, 60, 2);
    send_request(0, 63, 1'b1, 0, 62, 3, 61);
    send_request(63, 63, 1'b1, 0, 0, 61, 62);
    // an adjacent and a near target, far previous cells with all ones and zeros
    send_request(40, 40, 1'b1, 63, 63, 41, 41);
    send_request(21, 42, 1'b1, 0, 63, 22, 40);
    // one corner-to-corner route
    send_request(0, 0, 1'b1, 0, 0, 63, 63);

    for (int i = 0; i < 80; i++) begin
      if (i >= 68) allow_idle = 1'b0;
      send_random(i % 10 != 9);
    end
    @(negedge clk);
    start = 1'b0;

    while (sb.corner_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.corner_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
